FILE: sv/plane_equation_unit_assert.svh
// Assertion macros shared by the plane equation unit. Each macro expects
// i_clk and i_rst_n in the scope where it is used.
`ifndef PLANE_EQUATION_UNIT_ASSERT_SVH
`define PLANE_EQUATION_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PEU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PEU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/peu_pkg.sv
`default_nettype none

package peu_pkg;

    // Fixed field widths.
    localparam int IN_W   = 32;  // coordinate port width
    localparam int CRD_W  = 33;  // extracted coordinate, signed
    localparam int DIF_W  = 34;  // point difference, signed
    localparam int VEC_W  = 69;  // raw cross product component, signed
    localparam int W_W    = 32;  // scaled magnitude fed to square and divide
    localparam int OPD_W  = 35;  // signed multiplier operand
    localparam int MAG_W  = 34;  // multiplier operand magnitude
    localparam int HALF_W = 17;  // multiplier slice of operand B
    localparam int ACC_W  = 70;  // accumulator
    localparam int SQ_W   = 64;  // square root working width
    localparam int NRM_W  = 32;  // normal component
    localparam int OUT_W  = 34;  // offset and distance
    localparam int CNT_W  = 5;   // iteration counter
    localparam int SQ_STEPS = 32;
    localparam int NSH    = 8;   // coarse normalizing shift

    // Product phases: operand load, low slice, high slice.
    localparam logic [1:0] PH_LOAD = 2'd0;
    localparam logic [1:0] PH_LO   = 2'd1;
    localparam logic [1:0] PH_HI   = 2'd2;

    typedef enum logic [1:0] {
        ACT_POINT_NORMAL = 2'd0,
        ACT_THREE_POINTS = 2'd1,
        ACT_EVAL         = 2'd2,
        ACT_IGNORED      = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CROSS,
        S_ABS,
        S_NORM,
        S_SQ,
        S_SQRT_INIT,
        S_SQRT,
        S_DIV_INIT,
        S_DIV,
        S_NSET,
        S_DOT,
        S_TRUNC,
        S_FIN,
        S_OUT
    } t_state;

    // Multiplier operand pairs.
    typedef enum logic [3:0] {
        M_NONE,
        M_E1F2,
        M_E2F1,
        M_E2F0,
        M_E0F2,
        M_E0F1,
        M_E1F0,
        M_W0,
        M_W1,
        M_W2,
        M_AN0,
        M_AN1,
        M_AN2
    } t_msel;

    typedef struct packed {
        logic       load;
        logic       mac_load;
        logic       mac_lo;
        logic       mac_hi;
        logic       mac_clear;
        t_msel      sel;
        logic       store_v;
        logic [1:0] v_idx;
        logic       abs_en;
        logic       norm_step;
        logic       sq_init;
        logic       sq_step;
        logic       div_init;
        logic       div_step;
        logic       nset;
        logic       trunc;
        logic       fin;
        logic       eval;
        logic       set_degen;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic vec_zero;
        logic vec_ready;
    } t_stat;

endpackage

`default_nettype wire

FILE: sv/peu_ctrl.sv
`default_nettype none

`include "plane_equation_unit_assert.svh"

module peu_ctrl import peu_pkg::*; #(
    parameter int NORMAL_FRAC_BITS = 30
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [1:0] i_action,
    output logic            o_ready,
    output logic            o_valid,
    input  wire logic       i_ready,
    input  wire t_stat      i_stat,
    output t_cmd            o_cmd
);

    t_state     r_state, n_state;
    t_action    r_act, n_act;
    logic [2:0] r_prod, n_prod;
    logic [1:0] r_ph, n_ph;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic       r_ovalid, n_ovalid;
    logic       prod_last3;
    logic       prod_last6;
    logic       slot_free;

    assign prod_last3 = (r_prod == 3'd2) && (r_ph == PH_HI);
    assign prod_last6 = (r_prod == 3'd5) && (r_ph == PH_HI);
    assign slot_free  = !r_ovalid || i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (t_action'(i_action))
                        ACT_POINT_NORMAL: n_state = S_ABS;
                        ACT_THREE_POINTS: n_state = S_CROSS;
                        ACT_EVAL:         n_state = S_DOT;
                        default:          n_state = S_OUT;
                    endcase
                end
            end
            S_CROSS: if (prod_last6) n_state = S_ABS;
            S_ABS: n_state = S_NORM;
            S_NORM: begin
                if (i_stat.vec_zero) begin
                    n_state = S_OUT;
                end else if (i_stat.vec_ready) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: if (prod_last3) n_state = S_SQRT_INIT;
            S_SQRT_INIT: n_state = S_SQRT;
            S_SQRT: if (r_cnt == CNT_W'(SQ_STEPS - 1)) n_state = S_DIV_INIT;
            S_DIV_INIT: n_state = S_DIV;
            S_DIV: if (r_cnt == CNT_W'(NORMAL_FRAC_BITS - 1)) n_state = S_NSET;
            S_NSET: n_state = S_DOT;
            S_DOT: if (prod_last3) n_state = S_TRUNC;
            S_TRUNC: n_state = S_FIN;
            S_FIN: n_state = S_OUT;
            S_OUT: if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.eval = (r_act == ACT_EVAL);
        case (r_state)
            S_IDLE: o_cmd.load = i_valid;
            S_CROSS: begin
                o_cmd.mac_load  = (r_ph == PH_LOAD);
                o_cmd.mac_lo    = (r_ph == PH_LO);
                o_cmd.mac_hi    = (r_ph == PH_HI);
                o_cmd.mac_clear = (r_ph == PH_LO) && !r_prod[0];
                o_cmd.store_v   = (r_ph == PH_HI) && r_prod[0];
                o_cmd.v_idx     = r_prod[2:1];
                case (r_prod)
                    3'd0:    o_cmd.sel = M_E1F2;
                    3'd1:    o_cmd.sel = M_E2F1;
                    3'd2:    o_cmd.sel = M_E2F0;
                    3'd3:    o_cmd.sel = M_E0F2;
                    3'd4:    o_cmd.sel = M_E0F1;
                    3'd5:    o_cmd.sel = M_E1F0;
                    default: o_cmd.sel = M_NONE;
                endcase
            end
            S_ABS: o_cmd.abs_en = 1'b1;
            S_NORM: begin
                o_cmd.norm_step = !i_stat.vec_zero && !i_stat.vec_ready;
                o_cmd.set_degen = i_stat.vec_zero;
            end
            S_SQ, S_DOT: begin
                o_cmd.mac_load  = (r_ph == PH_LOAD);
                o_cmd.mac_lo    = (r_ph == PH_LO);
                o_cmd.mac_hi    = (r_ph == PH_HI);
                o_cmd.mac_clear = (r_ph == PH_LO) && (r_prod == 3'd0);
                case (r_prod)
                    3'd0:    o_cmd.sel = (r_state == S_SQ) ? M_W0 : M_AN0;
                    3'd1:    o_cmd.sel = (r_state == S_SQ) ? M_W1 : M_AN1;
                    3'd2:    o_cmd.sel = (r_state == S_SQ) ? M_W2 : M_AN2;
                    default: o_cmd.sel = M_NONE;
                endcase
            end
            S_SQRT_INIT: o_cmd.sq_init  = 1'b1;
            S_SQRT:      o_cmd.sq_step  = 1'b1;
            S_DIV_INIT:  o_cmd.div_init = 1'b1;
            S_DIV:       o_cmd.div_step = 1'b1;
            S_NSET:      o_cmd.nset     = 1'b1;
            S_TRUNC:     o_cmd.trunc    = 1'b1;
            S_FIN:       o_cmd.fin      = 1'b1;
            S_OUT:       o_cmd.out_load = slot_free;
            default: ;
        endcase
    end

    always_comb begin
        n_act    = r_act;
        n_prod   = r_prod;
        n_ph     = r_ph;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid;
        if ((r_state == S_IDLE) && i_valid) begin
            n_act = t_action'(i_action);
        end
        if (n_state != r_state) begin
            n_prod = '0;
            n_ph   = PH_LOAD;
            n_cnt  = '0;
        end else begin
            if (r_ph == PH_HI) begin
                n_ph   = PH_LOAD;
                n_prod = r_prod + 3'd1;
            end else begin
                n_ph = r_ph + 2'd1;
            end
            n_cnt = r_cnt + CNT_W'(1);
        end
        if (o_cmd.out_load) begin
            n_ovalid = 1'b1;
        end else if (i_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_act    <= ACT_POINT_NORMAL;
            r_prod   <= '0;
            r_ph     <= PH_LOAD;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_act    <= n_act;
            r_prod   <= n_prod;
            r_ph     <= n_ph;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;

    `PEU_ASSERT_NOW(a_out_slot_free, o_cmd.out_load, (!r_ovalid || i_ready), "result overwritten before transfer")
    `PEU_ASSERT_NEXT(a_accept_leaves_idle, (r_state == S_IDLE) && i_valid, r_state != S_IDLE, "accepted item not started")
    `PEU_ASSERT_NOW(a_div_count, r_state == S_DIV, r_cnt < CNT_W'(NORMAL_FRAC_BITS), "divide ran past its quotient length")

endmodule

`default_nettype wire

FILE: sv/peu_datapath.sv
`default_nettype none

`include "plane_equation_unit_assert.svh"

module peu_datapath import peu_pkg::*; #(
    parameter int COORD_WIDTH      = 32,
    parameter int NORMAL_FRAC_BITS = 30
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cmd                    i_cmd,
    input  wire logic signed [IN_W-1:0]  i_point_a_x,
    input  wire logic signed [IN_W-1:0]  i_point_a_y,
    input  wire logic signed [IN_W-1:0]  i_point_a_z,
    input  wire logic signed [IN_W-1:0]  i_point_b_x,
    input  wire logic signed [IN_W-1:0]  i_point_b_y,
    input  wire logic signed [IN_W-1:0]  i_point_b_z,
    input  wire logic signed [IN_W-1:0]  i_point_c_x,
    input  wire logic signed [IN_W-1:0]  i_point_c_y,
    input  wire logic signed [IN_W-1:0]  i_point_c_z,
    output t_stat                        o_stat,
    output logic signed [NRM_W-1:0]      o_unit_normal_x,
    output logic signed [NRM_W-1:0]      o_unit_normal_y,
    output logic signed [NRM_W-1:0]      o_unit_normal_z,
    output logic signed [OUT_W-1:0]      o_offset_out,
    output logic signed [OUT_W-1:0]      o_signed_distance,
    output logic                         o_degenerate
);

    localparam int NFB      = NORMAL_FRAC_BITS;
    localparam int QW       = NFB + 1;
    localparam int SIGN_EXT = (COORD_WIDTH <= IN_W) ? 1 : 0;
    localparam int SB       = (COORD_WIDTH <= IN_W) ? COORD_WIDTH - 1 : IN_W - 1;
    localparam int TOP      = W_W - 1;
    localparam int RES_W    = ACC_W + 1;
    localparam logic [ACC_W-1:0] BIAS = (ACC_W'(1) << NFB) - ACC_W'(1);
    localparam logic signed [NRM_W-1:0] NLIM = NRM_W'(1) << NFB;

    // Low COORD_WIDTH bits, sign-extended; wider settings keep all port bits.
    function automatic logic signed [CRD_W-1:0] f_coord(input logic [IN_W-1:0] x);
        logic [CRD_W-1:0] xe;
        logic [CRD_W-1:0] r;
        xe = {1'b0, x};
        for (int k = 0; k < CRD_W; k++) begin
            if (k <= SB) begin
                r[k] = xe[k];
            end else begin
                r[k] = (SIGN_EXT != 0) ? xe[SB] : 1'b0;
            end
        end
        return r;
    endfunction

    logic signed [CRD_W-1:0] a_in [3];
    logic signed [CRD_W-1:0] b_in [3];
    logic signed [CRD_W-1:0] c_in [3];

    logic signed [CRD_W-1:0] r_a [3];
    logic signed [DIF_W-1:0] r_e [3];
    logic signed [DIF_W-1:0] r_f [3];
    logic [VEC_W-1:0]        r_v [3];
    logic [VEC_W-1:0]        r_m [3];
    logic [2:0]              r_vneg;

    logic [MAG_W-1:0]        r_ma, r_mb;
    logic                    r_mneg;
    logic [ACC_W-1:0]        r_acc;

    logic [SQ_W-1:0]         r_sx, r_sr, r_sbit;
    logic [W_W-1:0]          r_drem [3];
    logic [QW-1:0]           r_q [3];
    logic signed [NRM_W-1:0] r_nn [3];
    logic signed [ACC_W-1:0] r_t;

    logic signed [NRM_W-1:0] r_nrm [3];
    logic signed [OUT_W-1:0] r_off;
    logic signed [OUT_W-1:0] r_dist;
    logic                    r_degen;

    logic signed [NRM_W-1:0] r_o_nx, r_o_ny, r_o_nz;
    logic signed [OUT_W-1:0] r_o_off, r_o_dist;
    logic                    r_o_degen;

    logic signed [OPD_W-1:0] opa, opb, opa_abs, opb_abs;
    logic signed [NRM_W-1:0] nsel [3];
    logic                    sub;
    logic [HALF_W-1:0]       mb_part;
    logic [MAG_W+HALF_W-1:0] pp;
    logic [ACC_W-1:0]        pp_sh, term, acc_base, acc_next;

    logic [VEC_W-1:0]        orv;
    logic [SQ_W-1:0]         sq_trial;
    logic [W_W-1:0]          root;
    logic [W_W:0]            rem2 [3];
    logic                    ge [3];
    logic [ACC_W-1:0]        tsum;
    logic signed [RES_W-1:0] fin_val;
    logic                    sat_pos, sat_neg;
    logic signed [OUT_W-1:0] sat_val;
    logic                    root_ok, nn_ok;

    always_comb begin
        a_in[0] = f_coord(i_point_a_x);
        a_in[1] = f_coord(i_point_a_y);
        a_in[2] = f_coord(i_point_a_z);
        b_in[0] = f_coord(i_point_b_x);
        b_in[1] = f_coord(i_point_b_y);
        b_in[2] = f_coord(i_point_b_z);
        c_in[0] = f_coord(i_point_c_x);
        c_in[1] = f_coord(i_point_c_y);
        c_in[2] = f_coord(i_point_c_z);
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nsel[i] = i_cmd.eval ? r_nrm[i] : r_nn[i];
        end
        opa = '0;
        opb = '0;
        case (i_cmd.sel)
            M_E1F2: begin opa = OPD_W'(r_e[1]); opb = OPD_W'(r_f[2]); end
            M_E2F1: begin opa = OPD_W'(r_e[2]); opb = OPD_W'(r_f[1]); end
            M_E2F0: begin opa = OPD_W'(r_e[2]); opb = OPD_W'(r_f[0]); end
            M_E0F2: begin opa = OPD_W'(r_e[0]); opb = OPD_W'(r_f[2]); end
            M_E0F1: begin opa = OPD_W'(r_e[0]); opb = OPD_W'(r_f[1]); end
            M_E1F0: begin opa = OPD_W'(r_e[1]); opb = OPD_W'(r_f[0]); end
            M_W0: begin
                opa = {{(OPD_W-W_W){1'b0}}, r_m[0][W_W-1:0]};
                opb = opa;
            end
            M_W1: begin
                opa = {{(OPD_W-W_W){1'b0}}, r_m[1][W_W-1:0]};
                opb = opa;
            end
            M_W2: begin
                opa = {{(OPD_W-W_W){1'b0}}, r_m[2][W_W-1:0]};
                opb = opa;
            end
            M_AN0: begin opa = OPD_W'(r_a[0]); opb = OPD_W'(nsel[0]); end
            M_AN1: begin opa = OPD_W'(r_a[1]); opb = OPD_W'(nsel[1]); end
            M_AN2: begin opa = OPD_W'(r_a[2]); opb = OPD_W'(nsel[2]); end
            default: begin opa = '0; opb = '0; end
        endcase
        sub     = i_cmd.sel inside {M_E2F1, M_E0F2, M_E1F0};
        opa_abs = opa[OPD_W-1] ? -opa : opa;
        opb_abs = opb[OPD_W-1] ? -opb : opb;
    end

    // One slice of the product per cycle, added into the accumulator.
    always_comb begin
        mb_part  = i_cmd.mac_hi ? r_mb[MAG_W-1:HALF_W] : r_mb[HALF_W-1:0];
        pp       = r_ma * mb_part;
        pp_sh    = i_cmd.mac_hi ? (ACC_W'(pp) << HALF_W) : ACC_W'(pp);
        term     = r_mneg ? -pp_sh : pp_sh;
        acc_base = i_cmd.mac_clear ? '0 : r_acc;
        acc_next = acc_base + term;
    end

    always_comb begin
        orv = r_m[0] | r_m[1] | r_m[2];
        o_stat.vec_zero  = (orv == '0);
        o_stat.vec_ready = (orv[VEC_W-1:TOP] == '0) && orv[TOP-1];
        sq_trial = r_sr + r_sbit;
        root     = r_sr[W_W-1:0];
        for (int i = 0; i < 3; i++) begin
            rem2[i] = {r_drem[i], 1'b0};
            ge[i]   = rem2[i] >= {1'b0, root};
        end
        tsum    = r_acc + (r_acc[ACC_W-1] ? BIAS : '0);
        fin_val = i_cmd.eval ? (RES_W'(r_t) + RES_W'(r_off)) : -RES_W'(r_t);
        sat_pos = !fin_val[RES_W-1] && (fin_val[RES_W-2:OUT_W-1] != '0);
        sat_neg = fin_val[RES_W-1] && (fin_val[RES_W-2:OUT_W-1] != '1);
        if (sat_pos) begin
            sat_val = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (sat_neg) begin
            sat_val = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            sat_val = fin_val[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= a_in[i];
                r_e[i] <= DIF_W'(b_in[i]) - DIF_W'(a_in[i]);
                r_f[i] <= DIF_W'(c_in[i]) - DIF_W'(a_in[i]);
                r_v[i] <= VEC_W'(b_in[i]);
            end
            r_dist  <= '0;
            r_degen <= 1'b0;
        end
        if (i_cmd.mac_load) begin
            r_ma   <= opa_abs[MAG_W-1:0];
            r_mb   <= opb_abs[MAG_W-1:0];
            r_mneg <= opa[OPD_W-1] ^ opb[OPD_W-1] ^ sub;
        end
        if (i_cmd.mac_lo || i_cmd.mac_hi) begin
            r_acc <= acc_next;
        end
        if (i_cmd.store_v) begin
            r_v[i_cmd.v_idx] <= acc_next[VEC_W-1:0];
        end
        if (i_cmd.abs_en) begin
            for (int i = 0; i < 3; i++) begin
                r_m[i]    <= r_v[i][VEC_W-1] ? -r_v[i] : r_v[i];
                r_vneg[i] <= r_v[i][VEC_W-1];
            end
        end
        if (i_cmd.norm_step) begin
            for (int i = 0; i < 3; i++) begin
                if (orv[VEC_W-1:TOP+NSH] != '0) begin
                    r_m[i] <= r_m[i] >> NSH;
                end else if (orv[VEC_W-1:TOP] != '0) begin
                    r_m[i] <= r_m[i] >> 1;
                end else if (orv[TOP-1:TOP-1-NSH] == '0) begin
                    r_m[i] <= r_m[i] << NSH;
                end else begin
                    r_m[i] <= r_m[i] << 1;
                end
            end
        end
        if (i_cmd.set_degen) begin
            r_degen <= 1'b1;
        end
        if (i_cmd.sq_init) begin
            r_sx   <= r_acc[SQ_W-1:0];
            r_sr   <= '0;
            r_sbit <= SQ_W'(1) << (SQ_W - 2);
        end
        if (i_cmd.sq_step) begin
            if (r_sx >= sq_trial) begin
                r_sx <= r_sx - sq_trial;
                r_sr <= (r_sr >> 1) + r_sbit;
            end else begin
                r_sr <= r_sr >> 1;
            end
            r_sbit <= r_sbit >> 2;
        end
        if (i_cmd.div_init) begin
            for (int i = 0; i < 3; i++) begin
                if (r_m[i][W_W-1:0] >= root) begin
                    r_drem[i] <= r_m[i][W_W-1:0] - root;
                    r_q[i]    <= QW'(1);
                end else begin
                    r_drem[i] <= r_m[i][W_W-1:0];
                    r_q[i]    <= '0;
                end
            end
        end
        if (i_cmd.div_step) begin
            for (int i = 0; i < 3; i++) begin
                r_drem[i] <= ge[i] ? W_W'(rem2[i] - {1'b0, root}) : W_W'(rem2[i]);
                r_q[i]    <= {r_q[i][QW-2:0], ge[i]};
            end
        end
        if (i_cmd.nset) begin
            for (int i = 0; i < 3; i++) begin
                r_nn[i] <= r_vneg[i] ? -NRM_W'(r_q[i]) : NRM_W'(r_q[i]);
            end
        end
        if (i_cmd.trunc) begin
            r_t <= $signed(tsum) >>> NFB;
        end
        if (i_cmd.fin && i_cmd.eval) begin
            r_dist <= sat_val;
        end
        if (i_cmd.out_load) begin
            r_o_nx    <= r_nrm[0];
            r_o_ny    <= r_nrm[1];
            r_o_nz    <= r_nrm[2];
            r_o_off   <= r_off;
            r_o_dist  <= r_dist;
            r_o_degen <= r_degen;
        end
    end

    // The plane itself resets to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_nrm[i] <= '0;
            end
            r_off <= '0;
        end else if (i_cmd.fin && !i_cmd.eval) begin
            for (int i = 0; i < 3; i++) begin
                r_nrm[i] <= r_nn[i];
            end
            r_off <= sat_val;
        end
    end

    assign o_unit_normal_x   = r_o_nx;
    assign o_unit_normal_y   = r_o_ny;
    assign o_unit_normal_z   = r_o_nz;
    assign o_offset_out      = r_o_off;
    assign o_signed_distance = r_o_dist;
    assign o_degenerate      = r_o_degen;

    assign root_ok = (r_sr[SQ_W-1:W_W] == '0) && (r_sr[W_W-1:W_W-2] != 2'b00);
    assign nn_ok   = (r_nn[0] <= NLIM) && (r_nn[0] >= -NLIM) &&
                     (r_nn[1] <= NLIM) && (r_nn[1] >= -NLIM) &&
                     (r_nn[2] <= NLIM) && (r_nn[2] >= -NLIM);

    `PEU_ASSERT_NEXT(a_norm_status, i_cmd.abs_en, !(o_stat.vec_zero && o_stat.vec_ready), "vector both zero and scaled")
    `PEU_ASSERT_NOW(a_root_range, i_cmd.div_init, root_ok, "vector length out of range")
    `PEU_ASSERT_NEXT(a_normal_bound, i_cmd.nset, nn_ok, "normal exceeds unit length")

endmodule

`default_nettype wire

FILE: sv/plane_equation_unit.sv
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_action, i_point_{a,b,c}_{x,y,z}
// result    out        o_valid / i_ready    o_unit_normal_{x,y,z}, o_offset_out,
//                                           o_signed_distance, o_degenerate
//
// One item is in flight at a time; o_ready is high while the controller is idle.
// An evaluation runs three products, each through operand load, low slice and
// high slice, on the shared 34x17 multiplier. Setting a plane, from a direction
// or from three points, runs the normalizing shift, the 32-step square root and
// the bit-serial divide. Reset is synchronous and active low; it clears the plane
// to zero and empties the result register. A stalled result waits in its register
// while the next item is already accepted; only the final transfer of that item
// waits for it.
`default_nettype none

module plane_equation_unit import peu_pkg::*; #(
    parameter int COORD_WIDTH      = 32,
    parameter int NORMAL_FRAC_BITS = 30
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [1:0]              i_action,
    input  wire logic signed [IN_W-1:0]  i_point_a_x,
    input  wire logic signed [IN_W-1:0]  i_point_a_y,
    input  wire logic signed [IN_W-1:0]  i_point_a_z,
    input  wire logic signed [IN_W-1:0]  i_point_b_x,
    input  wire logic signed [IN_W-1:0]  i_point_b_y,
    input  wire logic signed [IN_W-1:0]  i_point_b_z,
    input  wire logic signed [IN_W-1:0]  i_point_c_x,
    input  wire logic signed [IN_W-1:0]  i_point_c_y,
    input  wire logic signed [IN_W-1:0]  i_point_c_z,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic signed [NRM_W-1:0]      o_unit_normal_x,
    output logic signed [NRM_W-1:0]      o_unit_normal_y,
    output logic signed [NRM_W-1:0]      o_unit_normal_z,
    output logic signed [OUT_W-1:0]      o_offset_out,
    output logic signed [OUT_W-1:0]      o_signed_distance,
    output logic                         o_degenerate
);

    // The controller sequences the shared multiplier, the normalizing shift,
    // the square root and the divide lanes; the datapath holds all values.
    t_cmd  cmd;
    t_stat stat;

    peu_ctrl #(
        .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    peu_datapath #(
        .COORD_WIDTH      (COORD_WIDTH),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_point_a_x       (i_point_a_x),
        .i_point_a_y       (i_point_a_y),
        .i_point_a_z       (i_point_a_z),
        .i_point_b_x       (i_point_b_x),
        .i_point_b_y       (i_point_b_y),
        .i_point_b_z       (i_point_b_z),
        .i_point_c_x       (i_point_c_x),
        .i_point_c_y       (i_point_c_y),
        .i_point_c_z       (i_point_c_z),
        .o_stat            (stat),
        .o_unit_normal_x   (o_unit_normal_x),
        .o_unit_normal_y   (o_unit_normal_y),
        .o_unit_normal_z   (o_unit_normal_z),
        .o_offset_out      (o_offset_out),
        .o_signed_distance (o_signed_distance),
        .o_degenerate      (o_degenerate)
    );

endmodule

`default_nettype wire
